/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* rtl/hlcr_pkg.sv */
// ----------------------------------------------------------------------------
// hlcr_pkg
// Types, character codes and helper functions for the hex line receiver.
// ----------------------------------------------------------------------------
package hlcr_pkg;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CRC_INIT = 8'h00;
    localparam logic [7:0] CRC_POLY = 8'h07;

    // Byte count saturates at this value.
    localparam logic [1:0] CNT_MAX  = 2'd3;
    localparam logic [1:0] CNT_MIN_OK = 2'd2;

    // One result item as it leaves the decoder.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
        logic       frame_ok;
    } result_t;

    // Byte-wide CRC-8 step, MSB first, no reflection.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            if (v[7])
            begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

    // Returns the nibble value in the low bits; bit 4 set means not a hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'h10;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b0, c[3:0]};
        end
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
        begin
            // Letters a-f and A-F share the low nibble 1..6.
            r = {1'b0, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

/* rtl/hlcr_line_decoder.sv */
// ----------------------------------------------------------------------------
// hlcr_line_decoder
// Line state, hex pairing, CRC-8 and one-byte-late payload release.
// ----------------------------------------------------------------------------
module hlcr_line_decoder
    import hlcr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  char_in,
    output logic        res_valid,
    output result_t     res
);

    logic       at_start_reg, at_start_next;
    logic       colon_reg, colon_next;
    logic       hn_valid_reg, hn_valid_next;
    logic [3:0] hn_reg, hn_next;
    logic [7:0] held_reg, held_next;
    logic       held_valid_reg, held_valid_next;
    logic [1:0] cnt_reg, cnt_next;
    logic [7:0] crc_reg, crc_next;
    logic       last_cr_reg, last_cr_next;

    logic [4:0] nib;
    logic [7:0] new_byte;
    logic       colon_eff;
    logic       is_lf;
    logic       line_ok;

    assign nib       = hex_value(char_in);
    assign new_byte  = {hn_reg, nib[3:0]};
    assign colon_eff = at_start_reg ? (char_in == CH_COLON) : colon_reg;
    assign is_lf     = (char_in == CH_LF);
    assign line_ok   = colon_reg && last_cr_reg && !hn_valid_reg &&
                       (cnt_reg >= CNT_MIN_OK) && (crc_reg == 8'h00);

    // Next line state and the result of the current character.
    always_comb
    begin
        at_start_next   = at_start_reg;
        colon_next      = colon_reg;
        hn_valid_next   = hn_valid_reg;
        hn_next         = hn_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        cnt_next        = cnt_reg;
        crc_next        = crc_reg;
        last_cr_next    = last_cr_reg;
        res_valid       = 1'b0;
        res             = '0;

        if (step)
        begin
            if (is_lf)
            begin
                // End of line: report the verdict and return to the line start.
                res_valid       = 1'b1;
                res.frame_end   = 1'b1;
                res.frame_ok    = line_ok;
                at_start_next   = 1'b1;
                colon_next      = 1'b0;
                hn_valid_next   = 1'b0;
                hn_next         = 4'h0;
                held_next       = 8'h00;
                held_valid_next = 1'b0;
                cnt_next        = 2'd0;
                crc_next        = CRC_INIT;
                last_cr_next    = 1'b0;
            end
            else
            begin
                at_start_next = 1'b0;
                colon_next    = colon_eff;
                last_cr_next  = (char_in == CH_CR);
                if (!nib[4])
                begin
                    if (!hn_valid_reg)
                    begin
                        hn_next       = nib[3:0];
                        hn_valid_next = 1'b1;
                    end
                    else
                    begin
                        // A full byte: update CRC, release the previous byte.
                        hn_valid_next   = 1'b0;
                        hn_next         = 4'h0;
                        crc_next        = crc8_update(crc_reg, new_byte);
                        if (cnt_reg != CNT_MAX)
                        begin
                            cnt_next = cnt_reg + 2'd1;
                        end
                        if (held_valid_reg && colon_eff)
                        begin
                            res_valid     = 1'b1;
                            res.data_byte = held_reg;
                        end
                        held_next       = new_byte;
                        held_valid_next = 1'b1;
                    end
                end
            end
        end
    end

    // Line state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_start_reg   <= 1'b1;
            colon_reg      <= 1'b0;
            hn_valid_reg   <= 1'b0;
            hn_reg         <= 4'h0;
            held_reg       <= 8'h00;
            held_valid_reg <= 1'b0;
            cnt_reg        <= 2'd0;
            crc_reg        <= CRC_INIT;
            last_cr_reg    <= 1'b0;
        end
        else
        begin
            at_start_reg   <= at_start_next;
            colon_reg      <= colon_next;
            hn_valid_reg   <= hn_valid_next;
            hn_reg         <= hn_next;
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
            cnt_reg        <= cnt_next;
            crc_reg        <= crc_next;
            last_cr_reg    <= last_cr_next;
        end
    end

endmodule

/* rtl/hex_line_crc8_frame_receiver.sv */
// ----------------------------------------------------------------------------
// hex_line_crc8_frame_receiver
// ASCII hex line receiver with CRC-8 check and one-byte-late payload output.
// ----------------------------------------------------------------------------
// Usage:
//   Characters enter on rx_char with in_valid/in_ready; one transaction moves
//   one character. Results leave on data_byte, frame_end and frame_ok with
//   out_valid/out_ready; a payload byte has frame_end low, and each newline
//   gives an end marker with frame_end high and frame_ok as the line verdict.
//   A character is captured in an input register and decoded once the
//   result register is free or draining; its result, if any, is then
//   registered in the result register. Throughput is one character per
//   cycle while the receiver does not hold out_ready low with a result
//   pending; characters that cause no result also wait in that case.
//   When the receiver holds out_ready low with a result pending, the input
//   register fills and in_ready drops until the result is taken.
//   Reset clears the line state to the start of a line and empties both
//   the input and the result registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hex_line_crc8_frame_receiver
    import hlcr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  rx_char,
    input  logic        in_valid,
    output logic        in_ready,
    output logic [7:0]  data_byte,
    output logic        frame_end,
    output logic        frame_ok,
    output logic        out_valid,
    input  logic        out_ready
);

    logic [7:0] char_reg;
    logic       char_valid_reg, char_valid_next;
    logic       out_valid_reg, out_valid_next;
    result_t    res_reg;
    logic       advance;
    logic       dec_valid;
    result_t    dec_res;

    // The held character is decoded when the result slot is free or draining.
    assign advance  = char_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !char_valid_reg || advance;

    hlcr_line_decoder u_dec (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .char_in   (char_reg),
        .res_valid (dec_valid),
        .res       (dec_res)
    );

    // Valid flags of the input and result registers.
    always_comb
    begin
        char_valid_next = char_valid_reg;
        if (advance)
        begin
            char_valid_next = 1'b0;
        end
        if (in_valid && in_ready)
        begin
            char_valid_next = 1'b1;
        end

        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (advance && dec_valid)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            char_valid_reg <= char_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            char_reg <= rx_char;
        end
        if (advance && dec_valid)
        begin
            res_reg <= dec_res;
        end
    end

    assign out_valid = out_valid_reg;
    assign data_byte = res_reg.data_byte;
    assign frame_end = res_reg.frame_end;
    assign frame_ok  = res_reg.frame_ok;

    // An end marker always carries a zero data byte.
    `ASSERT_IMPLY(a_end_zero, out_valid && frame_end, data_byte == 8'h00, "end marker data not zero")
    // A payload byte never claims a good frame.
    `ASSERT_IMPLY(a_ok_only_end, out_valid && !frame_end, !frame_ok, "frame_ok on payload byte")
    // Input only stalls while a result waits on the receiver.
    `ASSERT_ALWAYS(a_stall_cause, in_ready || (out_valid && !out_ready), "input stalled without cause")

endmodule

/* test/hex_line_crc8_frame_checker.sv */
// ----------------------------------------------------------------------------
// hex_line_crc8_frame_checker
// Watches both channels of the hex line receiver, predicts every result from
// the accepted characters and compares the results that leave the block.
// ----------------------------------------------------------------------------
module hex_line_crc8_frame_checker
    import hlcr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  rx_char,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        frame_end,
    input  logic        frame_ok,
    input  logic        out_valid,
    input  logic        out_ready,
    output int          mismatches,
    output int          outstanding,
    output int          payload_seen,
    output int          lines_good,
    output int          lines_bad
);
    timeunit 1ns;
    timeprecision 1ps;

    // Line state of the predicted decoder.
    logic       line_fresh;
    logic       saw_colon;
    logic       nib_pending;
    logic [3:0] nib_hi;
    logic [7:0] prev_byte;
    logic       prev_byte_ok;
    logic [1:0] nbytes;
    logic [7:0] crc_acc;
    logic       cr_seen;

    // Decoded bytes and line verdicts that the block still owes.
    result_t    decoded_q[$];

    int n_mismatch = 0;
    int n_outstanding = 0;
    int n_payload = 0;
    int n_good = 0;
    int n_bad = 0;

    assign mismatches   = n_mismatch;
    assign outstanding  = n_outstanding;
    assign payload_seen = n_payload;
    assign lines_good   = n_good;
    assign lines_bad    = n_bad;

    // One CRC-8 byte step, polynomial x^8 + x^2 + x + 1, MSB first.
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] acc;
        acc = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            acc = acc[7] ? ({acc[6:0], 1'b0} ^ CRC_POLY) : {acc[6:0], 1'b0};
        end
        return acc;
    endfunction

    // Nibble value in the low bits; the top bit flags a non-hex character.
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
        begin
            return {1'b0, 4'(c - 8'h30)};
        end
        if (c >= 8'h41 && c <= 8'h46)
        begin
            return {1'b0, 4'(c - 8'h37)};
        end
        if (c >= 8'h61 && c <= 8'h66)
        begin
            return {1'b0, 4'(c - 8'h57)};
        end
        return 5'h10;
    endfunction

    // Everything returns to the start of a line.
    task automatic clear_line_state();
        line_fresh   = 1'b1;
        saw_colon    = 1'b0;
        nib_pending  = 1'b0;
        nib_hi       = 4'h0;
        prev_byte    = 8'h00;
        prev_byte_ok = 1'b0;
        nbytes       = 2'd0;
        crc_acc      = CRC_INIT;
        cr_seen      = 1'b0;
    endtask

    // Advances the predicted decoder by one character and queues its result.
    task automatic decode_char(input logic [7:0] c);
        logic [4:0] nib;
        logic [7:0] b;
        result_t    r;
        if (c == CH_LF)
        begin
            r.data_byte = 8'h00;
            r.frame_end = 1'b1;
            r.frame_ok  = saw_colon && cr_seen && !nib_pending &&
                          nbytes >= CNT_MIN_OK && crc_acc == 8'h00;
            decoded_q.push_back(r);
            clear_line_state();
        end
        else
        begin
            if (line_fresh)
            begin
                saw_colon  = (c == CH_COLON);
                line_fresh = 1'b0;
            end
            cr_seen = (c == CH_CR);
            nib = nibble_of(c);
            if (!nib[4])
            begin
                if (!nib_pending)
                begin
                    nib_hi      = nib[3:0];
                    nib_pending = 1'b1;
                end
                else
                begin
                    b           = {nib_hi, nib[3:0]};
                    nib_pending = 1'b0;
                    nib_hi      = 4'h0;
                    crc_acc     = crc8_step(crc_acc, b);
                    if (nbytes != CNT_MAX)
                    begin
                        nbytes = nbytes + 2'd1;
                    end
                    // The previous byte leaves only once a later byte proves
                    // it is not the checksum.
                    if (prev_byte_ok && saw_colon)
                    begin
                        r.data_byte = prev_byte;
                        r.frame_end = 1'b0;
                        r.frame_ok  = 1'b0;
                        decoded_q.push_back(r);
                    end
                    prev_byte    = b;
                    prev_byte_ok = 1'b1;
                end
            end
        end
    endtask

    // Compare the result leaving this cycle, then predict from the character
    // entering this cycle.
    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t due;
        if (!rst_n)
        begin
            clear_line_state();
            decoded_q.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (decoded_q.size() == 0)
                begin
                    n_mismatch++;
                    $error("unexpected result transaction: data_byte %02h frame_end %0b frame_ok %0b",
                           data_byte, frame_end, frame_ok);
                end
                else
                begin
                    due = decoded_q.pop_front();
                    if (data_byte !== due.data_byte)
                    begin
                        n_mismatch++;
                        $error("data_byte: expected %02h, actual %02h", due.data_byte, data_byte);
                    end
                    if (frame_end !== due.frame_end)
                    begin
                        n_mismatch++;
                        $error("frame_end: expected %0b, actual %0b", due.frame_end, frame_end);
                    end
                    if (frame_ok !== due.frame_ok)
                    begin
                        n_mismatch++;
                        $error("frame_ok: expected %0b, actual %0b", due.frame_ok, frame_ok);
                    end
                    if (!due.frame_end)
                    begin
                        n_payload++;
                    end
                    else if (due.frame_ok)
                    begin
                        n_good++;
                    end
                    else
                    begin
                        n_bad++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                decode_char(rx_char);
            end
        end
        n_outstanding = decoded_q.size();
    end

endmodule

/* test/hex_line_crc8_frame_receiver_test.sv */
// ----------------------------------------------------------------------------
// hex_line_crc8_frame_receiver_test
// Feeds the hex line receiver with directed lines and then random lines,
// mostly well framed with a correct CRC-8 and the rest broken or noisy, while
// both channels idle at random. A checker beside the block judges results.
// ----------------------------------------------------------------------------
module hex_line_crc8_frame_receiver_test
    import hlcr_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_CHARS = 1800;

    logic       clk = 1'b0;
    logic       rst_n;
    logic [7:0] rx_char;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] data_byte;
    logic       frame_end;
    logic       frame_ok;
    logic       out_valid;
    logic       out_ready;

    int mismatches;
    int outstanding;
    int payload_seen;
    int lines_good;
    int lines_bad;

    int  n_chars = 0;
    int  n_lines = 0;
    bit  steady_sender = 1'b0;

    hex_line_crc8_frame_receiver u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_char   (rx_char),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .frame_end (frame_end),
        .frame_ok  (frame_ok),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

    hex_line_crc8_frame_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx_char      (rx_char),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .frame_end    (frame_end),
        .frame_ok     (frame_ok),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .payload_seen (payload_seen),
        .lines_good   (lines_good),
        .lines_bad    (lines_bad)
    );

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Checksum byte generation for well-framed lines.
    function automatic logic [7:0] line_crc_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] acc;
        acc = crc ^ b;
        repeat (8)
        begin
            acc = acc[7] ? ({acc[6:0], 1'b0} ^ CRC_POLY) : {acc[6:0], 1'b0};
        end
        return acc;
    endfunction

    // ASCII hex digit, upper or lower case at random.
    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        if (n < 4'd10)
        begin
            return 8'h30 + 8'(n);
        end
        return ($urandom_range(0, 1) ? 8'h57 : 8'h37) + 8'(n);
    endfunction

    // A character that is neither a hex digit nor a newline.
    function automatic logic [7:0] filler_char();
        case ($urandom_range(0, 4))
            0:       return 8'($urandom_range(8'h00, 8'h09));
            1:       return 8'($urandom_range(8'h0B, 8'h2F));
            2:       return 8'($urandom_range(8'h3A, 8'h40));
            3:       return 8'($urandom_range(8'h47, 8'h60));
            default: return 8'($urandom_range(8'h67, 8'hFF));
        endcase
    endfunction

    // One character transaction, after a random gap unless the sender is steady.
    task automatic send_char(input logic [7:0] c);
        int pick;
        int gap;
        pick = $urandom_range(0, 99);
        if (steady_sender || pick < 70)
        begin
            gap = 0;
        end
        else if (pick < 93)
        begin
            gap = $urandom_range(1, 3);
        end
        else
        begin
            gap = $urandom_range(8, 40);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_char  <= c;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        n_chars++;
    endtask

    // Two hex digits, with an optional filler character in front.
    task automatic send_byte_hex(input logic [7:0] b, input bit noisy);
        if (noisy && $urandom_range(0, 3) == 0)
        begin
            send_char(filler_char());
        end
        send_char(hex_digit(b[7:4]));
        send_char(hex_digit(b[3:0]));
    endtask

    // One line: optional colon, payload, optional checksum (correct or
    // corrupted), optional lone digit, optional carriage return, newline.
    task automatic send_line(input logic [7:0] body[$], input bit colon, input bit cr,
                             input bit add_crc, input bit corrupt, input bit noisy,
                             input bit odd);
        logic [7:0] crc;
        crc = CRC_INIT;
        if (colon)
        begin
            send_char(CH_COLON);
        end
        foreach (body[k])
        begin
            send_byte_hex(body[k], noisy);
            crc = line_crc_step(crc, body[k]);
        end
        if (add_crc)
        begin
            send_byte_hex(crc ^ (corrupt ? 8'($urandom_range(1, 255)) : 8'h00), noisy);
        end
        if (odd)
        begin
            send_char(hex_digit(4'($urandom_range(0, 15))));
        end
        if (cr)
        begin
            send_char(CH_CR);
        end
        else if (noisy)
        begin
            send_char(filler_char());
        end
        send_char(CH_LF);
        n_lines++;
    endtask

    // Holds the sender off until every owed result has left the block.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat ($urandom_range(1, 6)) @(posedge clk);
    endtask

    // Receiver side: runs of ready and short or long stalls, with occasional
    // long stretches of no stall at all.
    initial
    begin
        int pick;
        int span;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
            begin
                out_ready <= 1'b1;
                span = $urandom_range(100, 300);
            end
            else if (pick < 55)
            begin
                out_ready <= 1'b1;
                span = $urandom_range(1, 8);
            end
            else if (pick < 90)
            begin
                out_ready <= 1'b0;
                span = $urandom_range(1, 3);
            end
            else
            begin
                out_ready <= 1'b0;
                span = $urandom_range(10, 50);
            end
            repeat (span) @(posedge clk);
        end
    end

    // Stimulus and verdict.
    initial
    begin
        logic [7:0] body[$];
        int         kind;
        int         len;
        int         line_no;
        int         goal;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        rx_char  <= 8'h00;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed lines: empty line, single byte, largest byte in a good
        // line, lone digit, line without a colon, missing carriage return.
        send_char(CH_LF);
        body = '{8'h00};
        send_line(body, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        body = '{8'hFF};
        send_line(body, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
        body.delete();
        send_line(body, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1);
        body = '{8'hA5};
        send_line(body, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        body = '{8'h00};
        send_line(body, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
        drain_results();

        // Random lines, mostly well framed with random content.
        goal    = n_chars + RANDOM_CHARS;
        line_no = 0;
        while (n_chars < goal)
        begin
            line_no++;
            if (line_no % 40 == 0)
            begin
                drain_results();
            end
            steady_sender = ($urandom_range(0, 4) == 0);
            len  = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 6);
            kind = $urandom_range(0, 99);
            body.delete();
            repeat (len) body.push_back(8'($urandom_range(0, 255)));
            if (kind < 55)
            begin
                send_line(body, 1'b1, 1'b1, 1'b1, 1'b0, $urandom_range(0, 3) == 0, 1'b0);
            end
            else if (kind < 65)
            begin
                send_line(body, 1'b1, 1'b1, 1'b1, 1'b1, $urandom_range(0, 3) == 0, 1'b0);
            end
            else if (kind < 71)
            begin
                send_line(body, 1'b0, 1'b1, 1'b1, 1'b0, $urandom_range(0, 3) == 0, 1'b0);
            end
            else if (kind < 77)
            begin
                send_line(body, 1'b1, 1'b0, 1'b1, 1'b0, 1'($urandom_range(0, 1)), 1'b0);
            end
            else if (kind < 83)
            begin
                send_line(body, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1);
            end
            else if (kind < 89)
            begin
                // Short lines around the two-byte minimum.
                body.delete();
                repeat ($urandom_range(0, 1)) body.push_back(8'($urandom_range(0, 255)));
                send_line(body, 1'b1, 1'b1, 1'($urandom_range(0, 1)), 1'b0, 1'b0, 1'b0);
            end
            else if (kind < 95)
            begin
                // Unframed noise over the full character range.
                repeat ($urandom_range(1, 12)) send_char(8'($urandom_range(0, 255)));
                send_char(CH_LF);
                n_lines++;
            end
            else
            begin
                // Filler only, no hex digits at all.
                if ($urandom_range(0, 1))
                begin
                    send_char(CH_COLON);
                end
                repeat ($urandom_range(0, 6)) send_char(filler_char());
                send_char(CH_LF);
                n_lines++;
            end
        end

        // Wait for the last results, then let the pipeline settle.
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);

        $display("Sent %0d characters in %0d lines under random idling on both channels.",
                 n_chars, n_lines);
        $display("Checked %0d payload bytes, %0d good and %0d rejected line markers.",
                 payload_seen, lines_good, lines_bad);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

    // Hard limit on the run time.
    initial
    begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
